>>> hdl/dtoe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device table package
// Shared types, sizes and codes for the device table with oldest eviction.
// ----------------------------------------------------------------------------
package dtoe_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int AddrW      = 48;
  localparam logic [7:0] TxpAbsent = 8'sd127;

  typedef enum logic [1:0] {
    OC_HIT   = 2'd0,
    OC_ALLOC = 2'd1,
    OC_EVICT = 2'd2,
    OC_EMPTY = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EVICT,
    ST_WRITE,
    ST_READ,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // latch the input beat
    logic scan_start;  // clear the scan index, start memory read at row 0 (at the read index in read mode)
    logic scan_step;   // compare the current row and advance
    logic evict_start;
    logic evict_step;
    logic do_write;    // write the chosen row
    logic do_read;     // read the addressed row
    logic load_out;    // load the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic mode;
    logic hit;        // current scanned row matches the key
    logic scan_last;  // current row is the last one to scan
    logic scan_none;  // table is empty
    logic full;
  } dp_stat_t;

endpackage

>>> hdl/dtoe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device table controller
// Sequences the key scan, eviction scan, row write and read for one beat.
// ----------------------------------------------------------------------------
module dtoe_ctrl
  import dtoe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     found
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   found_r, found_nxt;
  logic   pend_r, pend_nxt;  // registered scan read: rd_q data is valid in the next cycle

  assign out_valid = out_valid_r;
  assign found     = found_r;

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    pend_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          found_nxt = 1'b0;
          pend_nxt  = 1'b1;
          state_nxt = stat.mode ? ST_READ : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (pend_r) begin
          pend_nxt = 1'b0;
          if (stat.scan_none) begin
            state_nxt = stat.full ? ST_EVICT : ST_WRITE;
            pend_nxt  = stat.full;
          end
        end else if (stat.hit) begin
          found_nxt = 1'b1;
          state_nxt = ST_WRITE;
        end else if (stat.scan_last) begin
          state_nxt = stat.full ? ST_EVICT : ST_WRITE;
          pend_nxt  = stat.full;
        end else begin
          pend_nxt = 1'b1;
        end
      end
      ST_EVICT: begin
        if (pend_r) begin
          pend_nxt = 1'b0;
        end else if (stat.scan_last) begin
          state_nxt = ST_WRITE;
        end else begin
          pend_nxt = 1'b1;
        end
      end
      ST_WRITE: state_nxt = ST_OUT;
      ST_READ: begin
        if (!pend_r) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.capture    = in_valid;
        cmd.scan_start = in_valid;
      end
      ST_SEARCH: begin
        cmd.scan_step   = !pend_r && !stat.hit && !stat.scan_last;
        cmd.evict_start = stat.full && ((pend_r && stat.scan_none) ||
                          (!pend_r && !stat.hit && stat.scan_last));
      end
      ST_EVICT: cmd.evict_step = !pend_r;
      ST_WRITE: cmd.do_write = 1'b1;
      ST_READ:  cmd.do_read = 1'b1;
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      pend_r      <= pend_nxt;
    end
  end

endmodule

>>> hdl/dtoe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device table datapath
// Row memories, scan index, oldest tracker, row update and output register.
// ----------------------------------------------------------------------------
module dtoe_dp
  import dtoe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic              found,
  output dp_stat_t          stat,
  input  logic              in_mode,
  input  logic [AddrW-1:0]  in_dev_addr,
  input  logic [1:0]        in_dev_addr_type,
  input  logic signed [7:0] in_rssi_in,
  input  logic signed [7:0] in_tx_power_in,
  input  logic [15:0]       in_appearance_in,
  input  logic              in_connectable_in,
  input  logic [4:0]        in_tag_in,
  input  logic [31:0]       in_now_ms,
  input  logic [5:0]        in_read_index,
  output logic [5:0]        out_slot,
  output logic [1:0]        out_outcome,
  output logic [6:0]        out_entry_count,
  output logic [AddrW-1:0]  out_row_addr,
  output logic [1:0]        out_row_addr_type,
  output logic signed [7:0] out_row_rssi,
  output logic signed [7:0] out_row_tx_power,
  output logic [15:0]       out_row_appearance,
  output logic              out_row_connectable,
  output logic [4:0]        out_row_tag,
  output logic [31:0]       out_row_sightings,
  output logic [31:0]       out_row_last_seen
);

  localparam int RowW = AddrW + 2 + 8 + 8 + 16 + 1 + 5 + 32 + 32;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [1:0]       atype;
    logic [7:0]       rssi;
    logic [7:0]       txp;
    logic [15:0]      app;
    logic             conn;
    logic [4:0]       tag;
    logic [31:0]      cnt;
    logic [31:0]      seen;
  } row_t;

  logic [RowW-1:0] mem [TableDepth];
  row_t            rd_q;

  // Captured beat.
  logic [AddrW-1:0]  addr_r;
  logic [1:0]        atype_r;
  logic [7:0]        rssi_r, txp_r;
  logic [15:0]       app_r;
  logic              conn_r;
  logic [4:0]        tag_r;
  logic [31:0]       now_r;
  logic [5:0]        ridx_r;

  logic [CntW-1:0]   used_r, used_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;      // row currently presented by rd_q
  logic [IdxW-1:0]   best_r, best_nxt;
  logic [31:0]       best_seen_r, best_seen_nxt;
  logic              evicting_r, evicting_nxt;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   slot_sel;
  logic [1:0]        oc_sel;
  row_t              row_new, row_base;
  logic              wr_en;
  logic              read_ok;

  // The controller branches on the mode of the beat being accepted.
  assign stat.mode      = in_mode;
  assign stat.hit       = (rd_q.addr == addr_r);
  assign stat.scan_none = (used_r == '0);
  assign stat.full      = (used_r == CntW'(TableDepth));
  assign stat.scan_last = evicting_r ? (idx_r == IdxW'(TableDepth - 1))
                                     : (CntW'(idx_r) + CntW'(1) >= used_r);

  assign read_ok = (CntW'(ridx_r[IdxW-1:0]) < used_r) && ({26'd0, ridx_r} < TableDepth);

  always_comb begin
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    best_seen_nxt = best_seen_r;
    evicting_nxt  = evicting_r;
    rd_addr       = idx_r;
    if (cmd.scan_start) begin
      idx_nxt      = '0;
      evicting_nxt = 1'b0;
      rd_addr      = in_mode ? in_read_index[IdxW-1:0] : '0;
    end else if (cmd.evict_start) begin
      idx_nxt      = '0;
      evicting_nxt = 1'b1;
      rd_addr      = '0;
    end else if (cmd.scan_step || cmd.evict_step) begin
      if (cmd.evict_step) begin
        if (idx_r == '0 || rd_q.seen < best_seen_r) begin
          best_nxt      = idx_r;
          best_seen_nxt = rd_q.seen;
        end
      end
      idx_nxt = idx_r + IdxW'(1);
      rd_addr = idx_nxt;
    end else if (cmd.do_read) begin
      rd_addr = ridx_r[IdxW-1:0];
    end
  end

  // The last eviction compare happens in the final step; fold it in here.
  logic [IdxW-1:0] victim;
  always_comb begin
    victim = best_r;
    if (rd_q.seen < best_seen_r) victim = idx_r;
  end

  always_comb begin
    priority if (found) begin
      slot_sel = idx_r;
      oc_sel   = OC_HIT;
    end else if (!stat.full) begin
      slot_sel = used_r[IdxW-1:0];
      oc_sel   = OC_ALLOC;
    end else begin
      slot_sel = victim;
      oc_sel   = OC_EVICT;
    end
    row_base = found ? rd_q : '0;
    row_new       = row_base;
    row_new.addr  = addr_r;
    row_new.atype = atype_r;
    row_new.rssi  = rssi_r;
    row_new.cnt   = row_base.cnt + 32'd1;
    row_new.seen  = now_r;
    row_new.conn  = conn_r;
    if (txp_r != TxpAbsent) row_new.txp = txp_r;
    if (app_r != 16'd0) row_new.app = app_r;
    if (tag_r != 5'd0) row_new.tag = tag_r;
  end

  assign wr_en = cmd.do_write;
  assign used_nxt = (wr_en && !found && !stat.full) ? used_r + CntW'(1) : used_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[slot_sel] <= row_new;
    rd_q <= mem[rd_addr];
  end

  logic [5:0] res_slot_r;
  logic [1:0] res_oc_r;
  row_t       res_row_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r  <= in_dev_addr;
      atype_r <= in_dev_addr_type;
      rssi_r  <= in_rssi_in;
      txp_r   <= in_tx_power_in;
      app_r   <= in_appearance_in;
      conn_r  <= in_connectable_in;
      tag_r   <= in_tag_in;
      now_r   <= in_now_ms;
      ridx_r  <= in_read_index;
    end
    best_r      <= best_nxt;
    best_seen_r <= best_seen_nxt;
    if (wr_en) begin
      res_slot_r <= 6'(slot_sel);
      res_oc_r   <= oc_sel;
      res_row_r  <= row_new;
    end
    if (cmd.do_read) begin
      res_slot_r <= ridx_r;
      res_oc_r   <= read_ok ? OC_HIT : OC_EMPTY;
      res_row_r  <= read_ok ? rd_q : '0;
    end
    if (cmd.load_out) begin
      out_slot            <= res_slot_r;
      out_outcome         <= res_oc_r;
      out_entry_count     <= 7'(used_r);
      out_row_addr        <= res_row_r.addr;
      out_row_addr_type   <= res_row_r.atype;
      out_row_rssi        <= res_row_r.rssi;
      out_row_tx_power    <= res_row_r.txp;
      out_row_appearance  <= res_row_r.app;
      out_row_connectable <= res_row_r.conn;
      out_row_tag         <= res_row_r.tag;
      out_row_sightings   <= res_row_r.cnt;
      out_row_last_seen   <= res_row_r.seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      idx_r      <= '0;
      evicting_r <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      idx_r      <= idx_nxt;
      evicting_r <= evicting_nxt;
    end
  end

endmodule

>>> hdl/device_table_oldest_evict_core.sv
`timescale 1ns / 1ps
// Sequence: a read fetches the addressed row and loads the output register. A
// record scans the used rows until a hit or the last row, scans every row for the
// oldest when a full table must evict, then writes the row and loads the output.
// Flow: one beat at a time; a new result that waits for the previous one to be
// taken keeps in_ready low.
// Reset: rst_n clears the row count and control; row memory is not cleared.
// ----------------------------------------------------------------------------
// Device table core
// Top level joining the controller and datapath of the device table.
// ----------------------------------------------------------------------------
module device_table_oldest_evict_core
  import dtoe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [47:0]       in_dev_addr,
  input  logic [1:0]        in_dev_addr_type,
  input  logic signed [7:0] in_rssi_in,
  input  logic signed [7:0] in_tx_power_in,
  input  logic [15:0]       in_appearance_in,
  input  logic              in_connectable_in,
  input  logic [4:0]        in_tag_in,
  input  logic [31:0]       in_now_ms,
  input  logic [5:0]        in_read_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        out_slot,
  output logic [1:0]        out_outcome,
  output logic [6:0]        out_entry_count,
  output logic [47:0]       out_row_addr,
  output logic [1:0]        out_row_addr_type,
  output logic signed [7:0] out_row_rssi,
  output logic signed [7:0] out_row_tx_power,
  output logic [15:0]       out_row_appearance,
  output logic              out_row_connectable,
  output logic [4:0]        out_row_tag,
  output logic [31:0]       out_row_sightings,
  output logic [31:0]       out_row_last_seen
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     found;

  dtoe_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd, .found
  );

  dtoe_dp u_dp (
    .clk, .rst_n, .cmd, .found, .stat,
    .in_mode, .in_dev_addr, .in_dev_addr_type, .in_rssi_in, .in_tx_power_in,
    .in_appearance_in, .in_connectable_in, .in_tag_in, .in_now_ms,
    .in_read_index,
    .out_slot, .out_outcome, .out_entry_count, .out_row_addr,
    .out_row_addr_type, .out_row_rssi, .out_row_tx_power, .out_row_appearance,
    .out_row_connectable, .out_row_tag, .out_row_sightings, .out_row_last_seen
  );

endmodule

>>> hdl/dtoe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device table port checker
// Checks handshake and result properties seen at the core's ports.
// ----------------------------------------------------------------------------
module dtoe_checker
  import dtoe_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       in_valid,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_slot,
  input logic [1:0] out_outcome,
  input logic [6:0] out_entry_count
);

  // Only one beat is in flight, so the input closes right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot))
    else $error("result beat dropped or changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 7'(TableDepth))
    else $error("entry count above table depth");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OC_EVICT |-> out_entry_count == 7'(TableDepth))
    else $error("eviction reported while table not full");

  a_alloc_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OC_ALLOC |-> {1'b0, out_slot} + 7'd1 == out_entry_count)
    else $error("new row not appended at the end");

endmodule

bind device_table_oldest_evict_core dtoe_checker u_checker (
  .clk, .rst_n, .in_ready, .in_valid, .out_valid, .out_ready,
  .out_slot, .out_outcome, .out_entry_count
);
